### sv/xbt_pkg.sv
// xbt_pkg: shared types, codes and character helpers for the XML byte tokenizer.
// Depends on nothing; every other file of the block imports it.
`default_nettype none

package xbt_pkg;

   localparam int DEF_MAX_DEPTH = 255;
   localparam int DEF_WS_HOLD   = 16;
   localparam int Q_DEPTH       = 4;

   typedef enum logic [4:0] {
      M_IDLE, M_CONTENT, M_TEXT, M_LT, M_STAG, M_ATTR_WAIT, M_ANAME, M_AEQ,
      M_AVAL_WAIT, M_AVAL, M_SELFCLOSE, M_ENDNAME, M_BANG, M_COMMENT_OPEN,
      M_KW_CDATA, M_KW_DOCTYPE, M_COMMENT, M_CDATA, M_PI, M_DOCTYPE, M_DONE
   } mode_type;

   typedef enum logic [2:0] {
      PH_IDLE, PH_START, PH_PLAN, PH_FLUSH, PH_LIST, PH_FIN
   } phase_type;

   localparam logic [2:0] CLS_NONE    = 3'd0;
   localparam logic [2:0] CLS_ELEM    = 3'd1;
   localparam logic [2:0] CLS_ANAME   = 3'd2;
   localparam logic [2:0] CLS_AVAL    = 3'd3;
   localparam logic [2:0] CLS_CHARS   = 3'd4;
   localparam logic [2:0] CLS_COMMENT = 3'd5;
   localparam logic [2:0] CLS_ENDNAME = 3'd6;

   localparam logic [3:0] EV_NONE      = 4'd0;
   localparam logic [3:0] EV_START_DOC = 4'd1;
   localparam logic [3:0] EV_TAG_CLOSE = 4'd2;
   localparam logic [3:0] EV_ATTR_DONE = 4'd3;
   localparam logic [3:0] EV_END_ELEM  = 4'd4;
   localparam logic [3:0] EV_CHARS_END = 4'd5;
   localparam logic [3:0] EV_CMNT_END  = 4'd6;
   localparam logic [3:0] EV_END_DOC   = 4'd7;
   localparam logic [3:0] EV_ERROR     = 4'd8;

   localparam logic [7:0] CH_NUL   = 8'h00;
   localparam logic [7:0] CH_TAB   = 8'h09;
   localparam logic [7:0] CH_LF    = 8'h0A;
   localparam logic [7:0] CH_CR    = 8'h0D;
   localparam logic [7:0] CH_SP    = 8'h20;
   localparam logic [7:0] CH_BANG  = 8'h21;
   localparam logic [7:0] CH_DQ    = 8'h22;
   localparam logic [7:0] CH_SQ    = 8'h27;
   localparam logic [7:0] CH_DASH  = 8'h2D;
   localparam logic [7:0] CH_SLASH = 8'h2F;
   localparam logic [7:0] CH_LT    = 8'h3C;
   localparam logic [7:0] CH_EQ    = 8'h3D;
   localparam logic [7:0] CH_GT    = 8'h3E;
   localparam logic [7:0] CH_QM    = 8'h3F;
   localparam logic [7:0] CH_D     = 8'h44;
   localparam logic [7:0] CH_LBRK  = 8'h5B;
   localparam logic [7:0] CH_RBRK  = 8'h5D;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       byte_valid;
      logic [2:0] byte_class;
      logic [3:0] event_res;
      logic [7:0] nesting_depth;
      logic       run_last;
   } rsp_type;

   function automatic logic is_ws(input logic [7:0] c);
      return (c == CH_SP) || (c == CH_TAB) || (c == CH_LF) || (c == CH_CR);
   endfunction

   function automatic logic [1:0] ws_code(input logic [7:0] c);
      return (c == CH_TAB) ? 2'd1 : (c == CH_LF) ? 2'd2 : (c == CH_CR) ? 2'd3 : 2'd0;
   endfunction

   function automatic logic [7:0] ws_char(input logic [1:0] code);
      logic [7:0] r;
      unique case (code)
         2'd0: r = CH_SP;
         2'd1: r = CH_TAB;
         2'd2: r = CH_LF;
         2'd3: r = CH_CR;
      endcase
      return r;
   endfunction

   // "[CDATA[" and "DOCTYPE" keyword characters
   function automatic logic [7:0] kw_char(input logic cdata, input logic [2:0] idx);
      logic [7:0] r;
      case (idx)
         3'd0: r = cdata ? 8'h5B : 8'h44;
         3'd1: r = cdata ? 8'h43 : 8'h4F;
         3'd2: r = cdata ? 8'h44 : 8'h43;
         3'd3: r = cdata ? 8'h41 : 8'h54;
         3'd4: r = cdata ? 8'h54 : 8'h59;
         3'd5: r = cdata ? 8'h41 : 8'h50;
         3'd6: r = cdata ? 8'h5B : 8'h45;
         default: r = 8'h00;
      endcase
      return r;
   endfunction

endpackage

`default_nettype wire

### sv/xml_byte_tokenizer.sv
// Streaming XML tokenizer: one document byte per request beat, a run of result beats per byte.
// Top level; depends on xbt_pkg, xbt_front and xbt_queue.
`default_nettype none

// Feed the document one byte per req_ beat; req_input_end on the last byte also ends the
// document as if a zero byte followed. Each byte yields zero or more rsp_ beats, content
// bytes tagged with their class or structural events (start doc, tag closed, attribute
// done, end element, chars end, comment end, end doc, error), and rsp_run_last marks the
// final beat of each byte. After end doc or error, bytes are taken and give no beats until
// reset. rsp_nesting_depth carries the element depth after each beat (low 8 bits).
// Flow: the parser works on one byte at a time and takes the next byte only when it is done
// with the last; a byte with req_input_end set gets a second parse pass for the zero byte.
// A run of held whitespace is released one byte a cycle while the queue has room, each
// byte counted as a result beat.
// Beats wait in a four-deep output queue, so the parser only stalls when it fills up.
module xml_byte_tokenizer import xbt_pkg::*; #(
   parameter int MAX_DEPTH = DEF_MAX_DEPTH,
   parameter int WS_HOLD   = DEF_WS_HOLD
) (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   output logic            req_ready,
   input  wire logic [7:0] req_in_byte,
   input  wire logic       req_input_end,
   output logic            rsp_valid,
   input  wire logic       rsp_ready,
   output logic [7:0]      rsp_out_byte,
   output logic            rsp_byte_valid,
   output logic [2:0]      rsp_byte_class,
   output logic [3:0]      rsp_event_res,
   output logic [7:0]      rsp_nesting_depth,
   output logic            rsp_run_last
);

   logic    q_push, q_full;
   rsp_type q_data, head;

   // front end: parser and held-whitespace store
   xbt_front #(
      .MAX_DEPTH (MAX_DEPTH),
      .WS_HOLD   (WS_HOLD)
   ) u_front (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_in_byte   (req_in_byte),
      .req_input_end (req_input_end),
      .q_push        (q_push),
      .q_data        (q_data),
      .q_full        (q_full)
   );

   // back end: result queue drained by the rsp_ channel
   xbt_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (q_data),
      .full      (q_full),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .head      (head)
   );

   assign rsp_out_byte      = head.out_byte;
   assign rsp_byte_valid    = head.byte_valid;
   assign rsp_byte_class    = head.byte_class;
   assign rsp_event_res     = head.event_res;
   assign rsp_nesting_depth = head.nesting_depth;
   assign rsp_run_last      = head.run_last;

endmodule

`default_nettype wire

### sv/xbt_queue.sv
// xbt_queue: small result queue and output stage of the tokenizer.
// Depends on xbt_pkg (rsp_type, Q_DEPTH).
`default_nettype none

module xbt_queue import xbt_pkg::*; (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    push,
   input  wire rsp_type push_data,
   output logic         full,
   output logic         rsp_valid,
   input  wire logic    rsp_ready,
   output rsp_type      head
);

   localparam int PW = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
   localparam int CW = $clog2(Q_DEPTH + 1);

   rsp_type        store_ff [Q_DEPTH];
   logic [PW-1:0]  wr_ff, rd_ff;
   logic [CW-1:0]  count_ff;
   logic           pop;

   assign full      = (count_ff == CW'(Q_DEPTH));
   assign rsp_valid = (count_ff != '0);
   assign pop       = rsp_valid && rsp_ready;
   assign head      = store_ff[rd_ff];

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff    <= '0;
         rd_ff    <= '0;
         count_ff <= '0;
      end else begin
         if (push) begin
            wr_ff <= (wr_ff == PW'(Q_DEPTH - 1)) ? '0 : wr_ff + PW'(1);
         end
         if (pop) begin
            rd_ff <= (rd_ff == PW'(Q_DEPTH - 1)) ? '0 : rd_ff + PW'(1);
         end
         if (push && !pop) begin
            count_ff <= count_ff + CW'(1);
         end else if (pop && !push) begin
            count_ff <= count_ff - CW'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         store_ff[wr_ff] <= push_data;
      end
   end

endmodule

`default_nettype wire

### sv/xbt_front.sv
// xbt_front: byte parser state machine; turns each accepted byte into result beats.
// Depends on xbt_pkg; feeds xbt_queue through a one-beat holding register.
`default_nettype none

module xbt_front import xbt_pkg::*; #(
   parameter int MAX_DEPTH = DEF_MAX_DEPTH,
   parameter int WS_HOLD   = DEF_WS_HOLD
) (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   output logic            req_ready,
   input  wire logic [7:0] req_in_byte,
   input  wire logic       req_input_end,
   output logic            q_push,
   output rsp_type         q_data,
   input  wire logic       q_full
);

   localparam int DW = $clog2(MAX_DEPTH + 1);
   localparam int HW = $clog2(WS_HOLD + 1);
   localparam int AW = (WS_HOLD > 1) ? $clog2(WS_HOLD) : 1;

   phase_type      phase_ff, phase_in;
   mode_type       mode_ff, p_mode;
   logic [3:0]     kw_ff, p_kw;
   logic [1:0]     term_ff, p_term;
   logic           single_ff, p_single;
   logic [DW-1:0]  depth_ff, p_depth;
   logic [7:0]     dtn_ff, p_dtn;
   logic           nonempty_ff, p_nonempty;
   logic [HW-1:0]  held_ff, p_held;
   logic           p_flush, p_ws_we;
   rsp_type        p_ent [3];
   logic [1:0]     p_n;

   logic [1:0]     ws_mem [WS_HOLD];
   logic [1:0]     rd_ff;
   logic [7:0]     c_ff;
   logic           last_ff, pass_ff;
   rsp_type        list_ff [3];
   logic [1:0]     n_ff, li_ff;
   logic [HW-1:0]  fi_ff, fn_ff;
   rsp_type        pend_ff, gen_data;
   logic           pend_v_ff, gen_v, fin_push, room;
   logic           rd_en, to_pass2;
   logic [AW-1:0]  rd_addr;
   logic [7:0]     ch;

   function automatic logic [7:0] d8(input logic [DW-1:0] d);
      logic [DW+7:0] t;
      t = {8'd0, d};
      return t[7:0];
   endfunction

   function automatic rsp_type mk_byte(input logic [7:0] b, input logic [2:0] cls,
                                       input logic [DW-1:0] d);
      rsp_type r;
      r.out_byte      = b;
      r.byte_valid    = 1'b1;
      r.byte_class    = cls;
      r.event_res     = EV_NONE;
      r.nesting_depth = d8(d);
      r.run_last      = 1'b0;
      return r;
   endfunction

   function automatic rsp_type mk_ev(input logic [3:0] ev, input logic [DW-1:0] d);
      rsp_type r;
      r.out_byte      = 8'd0;
      r.byte_valid    = 1'b0;
      r.byte_class    = CLS_NONE;
      r.event_res     = ev;
      r.nesting_depth = d8(d);
      r.run_last      = 1'b0;
      return r;
   endfunction

   function automatic logic more_pass(input logic last, input logic pass, input mode_type m);
      return last && !pass && (m != M_DONE);
   endfunction

   assign room = !q_full;
   assign ch   = pass_ff ? CH_NUL : c_ff;

   // one parse step: results of this byte (after any held-whitespace flush) and new state
   always_comb begin : plan
      logic [1:0]    k;
      logic          at_max;
      logic [DW-1:0] dm;
      logic [1:0]    m, len;
      logic [7:0]    s0, s1, s2, sm, kwc;
      logic [2:0]    cls;
      k          = 2'd0;
      at_max     = (depth_ff >= DW'(MAX_DEPTH));
      dm         = depth_ff - DW'(1);
      p_mode     = mode_ff;
      p_kw       = kw_ff;
      p_term     = term_ff;
      p_single   = single_ff;
      p_depth    = depth_ff;
      p_dtn      = dtn_ff;
      p_nonempty = nonempty_ff;
      p_held     = held_ff;
      p_flush    = 1'b0;
      p_ws_we    = 1'b0;
      for (int i = 0; i < 3; i++) p_ent[i] = '0;
      s0  = (mode_ff == M_COMMENT) ? CH_DASH : (mode_ff == M_CDATA) ? CH_RBRK : CH_QM;
      s1  = (mode_ff == M_PI) ? CH_GT : s0;
      s2  = CH_GT;
      len = (mode_ff == M_PI) ? 2'd2 : 2'd3;
      cls = (mode_ff == M_COMMENT) ? CLS_COMMENT : (mode_ff == M_CDATA) ? CLS_CHARS : CLS_NONE;
      m   = (term_ff >= len) ? 2'd0 : term_ff;
      sm  = (m == 2'd0) ? s0 : (m == 2'd1) ? s1 : s2;
      kwc = kw_char(mode_ff == M_KW_CDATA, kw_ff[2:0]);

      unique case (mode_ff)
         M_CONTENT: begin
            if (ch == CH_NUL) begin
               p_ent[k] = mk_ev(EV_END_DOC, depth_ff); k = k + 2'd1; p_mode = M_DONE;
            end else if (is_ws(ch)) begin
               p_mode = M_CONTENT;
            end else if (ch == CH_LT) begin
               p_mode = M_LT;
            end else begin
               p_held = '0;
               p_ent[k] = mk_byte(ch, CLS_CHARS, depth_ff); k = k + 2'd1;
               p_mode = M_TEXT;
            end
         end
         M_TEXT: begin
            if (ch == CH_NUL) begin
               p_held = '0;
               p_ent[k] = mk_ev(EV_CHARS_END, depth_ff); k = k + 2'd1;
               p_ent[k] = mk_ev(EV_END_DOC, depth_ff); k = k + 2'd1;
               p_mode = M_DONE;
            end else if (ch == CH_LT) begin
               p_held = '0;
               p_ent[k] = mk_ev(EV_CHARS_END, depth_ff); k = k + 2'd1;
               p_mode = M_LT;
            end else if (is_ws(ch) && ({1'b0, held_ff} + (HW+1)'(1) < (HW+1)'(WS_HOLD))) begin
               p_ws_we = 1'b1;
               p_held  = held_ff + HW'(1);
            end else begin
               p_flush = 1'b1;
               p_held  = '0;
               p_ent[k] = mk_byte(ch, CLS_CHARS, depth_ff); k = k + 2'd1;
            end
         end
         M_LT: begin
            if (ch == CH_NUL) begin
               p_ent[k] = mk_ev(EV_ERROR, depth_ff); k = k + 2'd1; p_mode = M_DONE;
            end else if (ch == CH_BANG) begin
               p_mode = M_BANG;
            end else if (ch == CH_QM) begin
               p_term = 2'd0; p_mode = M_PI;
            end else if (ch == CH_SLASH) begin
               p_mode = M_ENDNAME;
            end else begin
               p_nonempty = 1'b0;
               p_mode     = M_STAG;
               if (ch == CH_GT) begin
                  p_ent[k] = mk_ev(EV_ERROR, depth_ff); k = k + 2'd1; p_mode = M_DONE;
               end else if (!is_ws(ch)) begin
                  p_nonempty = 1'b1;
                  p_ent[k] = mk_byte(ch, CLS_ELEM, depth_ff); k = k + 2'd1;
               end
            end
         end
         M_STAG: begin
            if (ch == CH_NUL ||
                (!nonempty_ff && (ch == CH_GT || ch == CH_SLASH))) begin
               p_ent[k] = mk_ev(EV_ERROR, depth_ff); k = k + 2'd1; p_mode = M_DONE;
            end else if (is_ws(ch)) begin
               if (nonempty_ff) p_mode = M_ATTR_WAIT;
            end else if (ch == CH_GT) begin
               if (at_max) begin
                  p_ent[k] = mk_ev(EV_ERROR, depth_ff); k = k + 2'd1; p_mode = M_DONE;
               end else begin
                  p_depth = depth_ff + DW'(1);
                  p_ent[k] = mk_ev(EV_TAG_CLOSE, p_depth); k = k + 2'd1;
                  p_mode = M_CONTENT;
               end
            end else if (ch == CH_SLASH) begin
               p_mode = M_SELFCLOSE;
            end else begin
               p_nonempty = 1'b1;
               p_ent[k] = mk_byte(ch, CLS_ELEM, depth_ff); k = k + 2'd1;
            end
         end
         M_ATTR_WAIT: begin
            if (ch == CH_NUL || ch == CH_EQ) begin
               p_ent[k] = mk_ev(EV_ERROR, depth_ff); k = k + 2'd1; p_mode = M_DONE;
            end else if (is_ws(ch)) begin
               p_mode = M_ATTR_WAIT;
            end else if (ch == CH_GT) begin
               if (at_max) begin
                  p_ent[k] = mk_ev(EV_ERROR, depth_ff); k = k + 2'd1; p_mode = M_DONE;
               end else begin
                  p_depth = depth_ff + DW'(1);
                  p_ent[k] = mk_ev(EV_TAG_CLOSE, p_depth); k = k + 2'd1;
                  p_mode = M_CONTENT;
               end
            end else if (ch == CH_SLASH) begin
               p_mode = M_SELFCLOSE;
            end else begin
               p_ent[k] = mk_byte(ch, CLS_ANAME, depth_ff); k = k + 2'd1;
               p_mode = M_ANAME;
            end
         end
         M_ANAME: begin
            if (ch == CH_NUL || ch == CH_GT) begin
               p_ent[k] = mk_ev(EV_ERROR, depth_ff); k = k + 2'd1; p_mode = M_DONE;
            end else if (is_ws(ch)) begin
               p_mode = M_AEQ;
            end else if (ch == CH_EQ) begin
               p_mode = M_AVAL_WAIT;
            end else begin
               p_ent[k] = mk_byte(ch, CLS_ANAME, depth_ff); k = k + 2'd1;
            end
         end
         M_AEQ: begin
            if (ch == CH_EQ) begin
               p_mode = M_AVAL_WAIT;
            end else if (!is_ws(ch)) begin
               p_ent[k] = mk_ev(EV_ERROR, depth_ff); k = k + 2'd1; p_mode = M_DONE;
            end
         end
         M_AVAL_WAIT: begin
            if (ch == CH_DQ) begin
               p_single = 1'b0; p_mode = M_AVAL;
            end else if (ch == CH_SQ) begin
               p_single = 1'b1; p_mode = M_AVAL;
            end else if (!is_ws(ch)) begin
               p_ent[k] = mk_ev(EV_ERROR, depth_ff); k = k + 2'd1; p_mode = M_DONE;
            end
         end
         M_AVAL: begin
            if (ch == CH_NUL || ch == CH_GT) begin
               p_ent[k] = mk_ev(EV_ERROR, depth_ff); k = k + 2'd1; p_mode = M_DONE;
            end else if (ch == (single_ff ? CH_SQ : CH_DQ)) begin
               p_ent[k] = mk_ev(EV_ATTR_DONE, depth_ff); k = k + 2'd1;
               p_mode = M_ATTR_WAIT;
            end else begin
               p_ent[k] = mk_byte(ch, CLS_AVAL, depth_ff); k = k + 2'd1;
            end
         end
         M_SELFCLOSE: begin
            if (ch != CH_GT || at_max) begin
               p_ent[k] = mk_ev(EV_ERROR, depth_ff); k = k + 2'd1; p_mode = M_DONE;
            end else begin
               p_ent[k] = mk_ev(EV_TAG_CLOSE, depth_ff + DW'(1)); k = k + 2'd1;
               p_ent[k] = mk_ev(EV_END_ELEM, depth_ff); k = k + 2'd1;
               if (depth_ff == '0) begin
                  p_ent[k] = mk_ev(EV_END_DOC, depth_ff); k = k + 2'd1; p_mode = M_DONE;
               end else begin
                  p_mode = M_CONTENT;
               end
            end
         end
         M_ENDNAME: begin
            if (ch == CH_NUL || (ch == CH_GT && depth_ff == '0)) begin
               p_ent[k] = mk_ev(EV_ERROR, depth_ff); k = k + 2'd1; p_mode = M_DONE;
            end else if (ch == CH_GT) begin
               p_depth = dm;
               p_ent[k] = mk_ev(EV_END_ELEM, dm); k = k + 2'd1;
               if (dm == '0) begin
                  p_ent[k] = mk_ev(EV_END_DOC, dm); k = k + 2'd1; p_mode = M_DONE;
               end else begin
                  p_mode = M_CONTENT;
               end
            end else begin
               p_ent[k] = mk_byte(ch, CLS_ENDNAME, depth_ff); k = k + 2'd1;
            end
         end
         M_BANG: begin
            if (ch == CH_DASH) begin
               p_mode = M_COMMENT_OPEN;
            end else if (ch == CH_LBRK) begin
               p_kw = 4'd1; p_mode = M_KW_CDATA;
            end else if (ch == CH_D) begin
               p_kw = 4'd1; p_mode = M_KW_DOCTYPE;
            end else begin
               p_ent[k] = mk_ev(EV_ERROR, depth_ff); k = k + 2'd1; p_mode = M_DONE;
            end
         end
         M_COMMENT_OPEN: begin
            if (ch == CH_DASH) begin
               p_term = 2'd0; p_mode = M_COMMENT;
            end else begin
               p_ent[k] = mk_ev(EV_ERROR, depth_ff); k = k + 2'd1; p_mode = M_DONE;
            end
         end
         M_KW_CDATA, M_KW_DOCTYPE: begin
            if (kw_ff >= 4'd7 || ch != kwc) begin
               p_ent[k] = mk_ev(EV_ERROR, depth_ff); k = k + 2'd1; p_mode = M_DONE;
            end else if (kw_ff == 4'd6) begin
               p_kw   = 4'd0;
               p_term = 2'd0;
               if (mode_ff == M_KW_CDATA) begin
                  p_mode = M_CDATA;
               end else begin
                  p_dtn  = 8'd1;
                  p_mode = M_DOCTYPE;
               end
            end else begin
               p_kw = kw_ff + 4'd1;
            end
         end
         M_COMMENT, M_CDATA, M_PI: begin
            if (ch == CH_NUL) begin
               p_ent[k] = mk_ev(EV_ERROR, depth_ff); k = k + 2'd1; p_mode = M_DONE;
            end else if (ch == sm) begin
               if (m + 2'd1 == len) begin
                  p_term = 2'd0;
                  p_mode = M_CONTENT;
                  if (mode_ff == M_COMMENT) begin
                     p_ent[k] = mk_ev(EV_CMNT_END, depth_ff); k = k + 2'd1;
                  end else if (mode_ff == M_CDATA) begin
                     p_ent[k] = mk_ev(EV_CHARS_END, depth_ff); k = k + 2'd1;
                  end
               end else begin
                  p_term = m + 2'd1;
               end
            end else if (m != 2'd0 && ch == s0) begin
               // broken partial match restarts on its first character
               if (cls != CLS_NONE) begin
                  p_ent[k] = mk_byte(s0, cls, depth_ff); k = k + 2'd1;
               end
            end else begin
               p_term = 2'd0;
               if (cls != CLS_NONE) begin
                  if (m >= 2'd1) begin
                     p_ent[k] = mk_byte(s0, cls, depth_ff); k = k + 2'd1;
                  end
                  if (m >= 2'd2) begin
                     p_ent[k] = mk_byte(s1, cls, depth_ff); k = k + 2'd1;
                  end
                  p_ent[k] = mk_byte(ch, cls, depth_ff); k = k + 2'd1;
               end
            end
         end
         M_DOCTYPE: begin
            if (ch == CH_NUL) begin
               p_ent[k] = mk_ev(EV_ERROR, depth_ff); k = k + 2'd1; p_mode = M_DONE;
            end else if (ch == CH_LT) begin
               if (dtn_ff != 8'hFF) p_dtn = dtn_ff + 8'd1;
            end else if (ch == CH_GT) begin
               p_dtn = (dtn_ff != 8'd0) ? dtn_ff - 8'd1 : 8'd0;
               if (p_dtn == 8'd0) p_mode = M_CONTENT;
            end
         end
         default: begin
            p_mode = mode_ff;
         end
      endcase
      p_n = k;
   end

   // next phase
   always_comb begin
      phase_in = phase_ff;
      unique case (phase_ff)
         PH_IDLE: begin
            if (req_valid) begin
               phase_in = (mode_ff == M_DONE) ? PH_FIN :
                          (mode_ff == M_IDLE) ? PH_START : PH_PLAN;
            end
         end
         PH_START: begin
            if (room) phase_in = PH_PLAN;
         end
         PH_PLAN: begin
            if (p_flush && held_ff != '0) begin
               phase_in = PH_FLUSH;
            end else if (p_n != 2'd0) begin
               phase_in = PH_LIST;
            end else begin
               phase_in = more_pass(last_ff, pass_ff, p_mode) ? PH_PLAN : PH_FIN;
            end
         end
         PH_FLUSH: begin
            if (room && fi_ff == fn_ff - HW'(1)) begin
               phase_in = (n_ff != 2'd0) ? PH_LIST :
                          more_pass(last_ff, pass_ff, mode_ff) ? PH_PLAN : PH_FIN;
            end
         end
         PH_LIST: begin
            if (room && li_ff == n_ff - 2'd1) begin
               phase_in = more_pass(last_ff, pass_ff, mode_ff) ? PH_PLAN : PH_FIN;
            end
         end
         PH_FIN: begin
            if (!pend_v_ff || room) phase_in = PH_IDLE;
         end
         default: phase_in = PH_IDLE;
      endcase
   end

   // phase outputs
   always_comb begin
      req_ready = 1'b0;
      gen_v     = 1'b0;
      gen_data  = '0;
      fin_push  = 1'b0;
      unique case (phase_ff)
         PH_IDLE:  req_ready = 1'b1;
         PH_START: begin
            gen_v    = room;
            gen_data = mk_ev(EV_START_DOC, depth_ff);
         end
         PH_PLAN:  gen_v = 1'b0;
         PH_FLUSH: begin
            gen_v    = room;
            gen_data = mk_byte(ws_char(rd_ff), CLS_CHARS, depth_ff);
         end
         PH_LIST: begin
            gen_v    = room;
            gen_data = list_ff[li_ff];
         end
         PH_FIN:   fin_push = pend_v_ff && room;
         default:  gen_v = 1'b0;
      endcase
   end

   assign to_pass2 = (phase_in == PH_PLAN) &&
                     (phase_ff == PH_PLAN || phase_ff == PH_FLUSH || phase_ff == PH_LIST);
   assign q_push   = (gen_v && pend_v_ff) || fin_push;
   always_comb begin
      q_data          = pend_ff;
      q_data.run_last = fin_push;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff    <= PH_IDLE;
         mode_ff     <= M_IDLE;
         kw_ff       <= '0;
         term_ff     <= '0;
         single_ff   <= 1'b0;
         depth_ff    <= '0;
         dtn_ff      <= '0;
         nonempty_ff <= 1'b0;
         held_ff     <= '0;
         pend_v_ff   <= 1'b0;
         pass_ff     <= 1'b0;
      end else begin
         phase_ff <= phase_in;
         if (phase_ff == PH_IDLE && req_valid) pass_ff <= 1'b0;
         if (to_pass2) pass_ff <= 1'b1;
         if (phase_ff == PH_START && room) mode_ff <= M_CONTENT;
         if (phase_ff == PH_PLAN) begin
            mode_ff     <= p_mode;
            kw_ff       <= p_kw;
            term_ff     <= p_term;
            single_ff   <= p_single;
            depth_ff    <= p_depth;
            dtn_ff      <= p_dtn;
            nonempty_ff <= p_nonempty;
            held_ff     <= p_held;
         end
         if (gen_v) begin
            pend_v_ff <= 1'b1;
         end else if (fin_push) begin
            pend_v_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (phase_ff == PH_IDLE && req_valid) begin
         c_ff    <= req_in_byte;
         last_ff <= req_input_end;
      end
      if (phase_ff == PH_PLAN) begin
         for (int i = 0; i < 3; i++) list_ff[i] <= p_ent[i];
         n_ff  <= p_n;
         li_ff <= 2'd0;
         fi_ff <= '0;
         fn_ff <= held_ff;
      end
      if (phase_ff == PH_FLUSH && room) fi_ff <= fi_ff + HW'(1);
      if (phase_ff == PH_LIST && room) li_ff <= li_ff + 2'd1;
      if (gen_v) pend_ff <= gen_data;
   end

   // held whitespace store: written per held byte, read one ahead during a flush
   assign rd_en   = (phase_ff == PH_PLAN) || (phase_ff == PH_FLUSH && room);
   always_comb begin
      logic [HW-1:0] nx;
      nx      = fi_ff + HW'(1);
      rd_addr = (phase_ff == PH_PLAN) ? '0 : nx[AW-1:0];
   end

   always_ff @(posedge clock) begin
      if (phase_ff == PH_PLAN && p_ws_we) ws_mem[held_ff[AW-1:0]] <= ws_code(ch);
      if (rd_en) rd_ff <= ws_mem[rd_addr];
   end

   a_held_bound: assert property (@(posedge clock) disable iff (reset)
      ({1'b0, held_ff} < (HW+1)'(WS_HOLD)))
      else $error("held whitespace count reached the hold size");

   a_depth_bound: assert property (@(posedge clock) disable iff (reset)
      ({1'b0, depth_ff} <= (DW+1)'(MAX_DEPTH)))
      else $error("depth counter above its limit");

   a_one_beat: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("second byte taken before the first was parsed");

   a_list_nonempty: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == PH_LIST) |-> (n_ff != 2'd0))
      else $error("result list phase with nothing to send");

endmodule

`default_nettype wire

### sim/xml_byte_tokenizer_test.sv
// Self-checking bench for xml_byte_tokenizer: one document fed byte by byte, beats predicted
// by a behavioral tokenizer in the bench and compared field by field. Depends on xbt_pkg.
`timescale 1ns / 1ps

module xml_byte_tokenizer_test import xbt_pkg::*; ();

   localparam int HOLD_LEN   = DEF_WS_HOLD;    // whitespace hold depth of the block
   localparam int DEPTH_CAP  = DEF_MAX_DEPTH;  // deepest legal nesting
   localparam int BEAT_CAP   = 18;             // most beats one byte can cause
   localparam int RAND_ITEMS = 15;

   logic       clock;
   logic       reset;
   logic       req_valid;
   logic       req_ready;
   logic [7:0] req_in_byte;
   logic       req_input_end;
   logic       rsp_valid;
   logic       rsp_ready;
   logic [7:0] rsp_out_byte;
   logic       rsp_byte_valid;
   logic [2:0] rsp_byte_class;
   logic [3:0] rsp_event_res;
   logic [7:0] rsp_nesting_depth;
   logic       rsp_run_last;

   xml_byte_tokenizer u_dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready),
      .req_in_byte(req_in_byte), .req_input_end(req_input_end),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready),
      .rsp_out_byte(rsp_out_byte), .rsp_byte_valid(rsp_byte_valid),
      .rsp_byte_class(rsp_byte_class), .rsp_event_res(rsp_event_res),
      .rsp_nesting_depth(rsp_nesting_depth), .rsp_run_last(rsp_run_last)
   );

   always begin
      clock = 1'b1; #5;
      clock = 1'b0; #5;
   end

   // ---------------------------------------------------------------
   // Tokenizer state as the bench sees it
   // ---------------------------------------------------------------
   mode_type   tk_mode;
   int         kw_pos;
   int         term_pos;
   bit         single_quote;
   int         tk_depth;
   int         dt_nest;
   bit         name_seen;
   logic [1:0] held_ws [HOLD_LEN];
   int         held_n;
   int         step_beats;

   rsp_type expected_beats [$];
   int      fail_count;
   int      beats_seen;
   int      bytes_sent;
   int      errors_seen;
   bit      quiet_req;      // sender offers back to back
   bit      quiet_rsp;      // receiver never stalls
   int      rsp_hold;       // long receiver hold-off request, in cycles
   string   ending_name;

   function automatic bit is_blank(input logic [7:0] c);
      return c == CH_SP || c == CH_TAB || c == CH_LF || c == CH_CR;
   endfunction

   function automatic logic [1:0] blank_code(input logic [7:0] c);
      return c == CH_TAB ? 2'd1 : c == CH_LF ? 2'd2 : c == CH_CR ? 2'd3 : 2'd0;
   endfunction

   function automatic logic [7:0] blank_char(input logic [1:0] code);
      return code == 2'd1 ? CH_TAB : code == 2'd2 ? CH_LF : code == 2'd3 ? CH_CR : CH_SP;
   endfunction

   task automatic emit(input logic [7:0] b, input logic v, input logic [2:0] cls,
                       input logic [3:0] ev);
      rsp_type r;
      if (step_beats >= BEAT_CAP) return;
      r = '0;
      r.out_byte      = b;
      r.byte_valid    = v;
      r.byte_class    = cls;
      r.event_res     = ev;
      r.nesting_depth = tk_depth[7:0];
      expected_beats.push_back(r);
      step_beats++;
   endtask

   task automatic emit_byte(input logic [7:0] b, input logic [2:0] cls);
      emit(b, 1'b1, cls, EV_NONE);
   endtask

   task automatic emit_event(input logic [3:0] ev);
      emit(8'h00, 1'b0, CLS_NONE, ev);
   endtask

   task automatic doc_error();
      emit_event(EV_ERROR);
      tk_mode = M_DONE;
   endtask

   task automatic doc_end();
      emit_event(EV_END_DOC);
      tk_mode = M_DONE;
   endtask

   task automatic release_held();
      for (int i = 0; i < held_n && i < HOLD_LEN; i++)
         emit_byte(blank_char(held_ws[i]), CLS_CHARS);
      held_n = 0;
   endtask

   // terminator tracking with prefix fallback; cls NONE delivers nothing
   task automatic match_term(input logic [7:0] seq [3], input int len, input logic [7:0] c,
                             input logic [2:0] cls, output bit hit);
      int m;
      m = term_pos;
      hit = 0;
      if (m >= len) m = 0;
      if (c == seq[m]) begin
         m++;
         if (m == len) begin
            term_pos = 0;
            hit = 1;
         end else
            term_pos = m;
      end else if (m > 0 && c == seq[0]) begin
         if (cls != CLS_NONE) emit_byte(seq[0], cls);
      end else begin
         if (cls != CLS_NONE) begin
            for (int i = 0; i < m; i++) emit_byte(seq[i], cls);
            emit_byte(c, cls);
         end
         term_pos = 0;
      end
   endtask

   task automatic open_tag_done();
      if (tk_depth >= DEPTH_CAP) begin
         doc_error();
         return;
      end
      tk_depth++;
      emit_event(EV_TAG_CLOSE);
      tk_mode = M_CONTENT;
   endtask

   task automatic parse_byte(input logic [7:0] c);
      logic [7:0] seq [3];
      logic [7:0] kw;
      bit         hit;
      case (tk_mode)
         M_CONTENT: begin
            if (c == CH_NUL) doc_end();
            else if (is_blank(c)) ;
            else if (c == CH_LT) tk_mode = M_LT;
            else begin
               held_n = 0;
               emit_byte(c, CLS_CHARS);
               tk_mode = M_TEXT;
            end
         end
         M_TEXT: begin
            if (c == CH_NUL) begin
               held_n = 0; emit_event(EV_CHARS_END); doc_end();
            end else if (c == CH_LT) begin
               held_n = 0; emit_event(EV_CHARS_END); tk_mode = M_LT;
            end else if (is_blank(c)) begin
               if (held_n + 1 >= HOLD_LEN) begin
                  release_held();
                  emit_byte(c, CLS_CHARS);
               end else begin
                  held_ws[held_n] = blank_code(c);
                  held_n++;
               end
            end else begin
               release_held();
               emit_byte(c, CLS_CHARS);
            end
         end
         M_LT: begin
            if (c == CH_NUL) doc_error();
            else if (c == CH_BANG) tk_mode = M_BANG;
            else if (c == CH_QM) begin term_pos = 0; tk_mode = M_PI; end
            else if (c == CH_SLASH) tk_mode = M_ENDNAME;
            else begin
               name_seen = 0;
               tk_mode = M_STAG;
               parse_byte(c);
            end
         end
         M_STAG: begin
            if (c == CH_NUL) doc_error();
            else if (is_blank(c)) begin if (name_seen) tk_mode = M_ATTR_WAIT; end
            else if (c == CH_GT) begin
               if (name_seen) open_tag_done(); else doc_error();
            end else if (c == CH_SLASH) begin
               if (name_seen) tk_mode = M_SELFCLOSE; else doc_error();
            end else begin
               name_seen = 1;
               emit_byte(c, CLS_ELEM);
            end
         end
         M_ATTR_WAIT: begin
            if (c == CH_NUL || c == CH_EQ) doc_error();
            else if (is_blank(c)) ;
            else if (c == CH_GT) open_tag_done();
            else if (c == CH_SLASH) tk_mode = M_SELFCLOSE;
            else begin emit_byte(c, CLS_ANAME); tk_mode = M_ANAME; end
         end
         M_ANAME: begin
            if (c == CH_NUL || c == CH_GT) doc_error();
            else if (is_blank(c)) tk_mode = M_AEQ;
            else if (c == CH_EQ) tk_mode = M_AVAL_WAIT;
            else emit_byte(c, CLS_ANAME);
         end
         M_AEQ: begin
            if (is_blank(c)) ;
            else if (c == CH_EQ) tk_mode = M_AVAL_WAIT;
            else doc_error();
         end
         M_AVAL_WAIT: begin
            if (is_blank(c)) ;
            else if (c == CH_DQ) begin single_quote = 0; tk_mode = M_AVAL; end
            else if (c == CH_SQ) begin single_quote = 1; tk_mode = M_AVAL; end
            else doc_error();
         end
         M_AVAL: begin
            if (c == CH_NUL || c == CH_GT) doc_error();
            else if (c == (single_quote ? CH_SQ : CH_DQ)) begin
               emit_event(EV_ATTR_DONE);
               tk_mode = M_ATTR_WAIT;
            end else emit_byte(c, CLS_AVAL);
         end
         M_SELFCLOSE: begin
            if (c != CH_GT || tk_depth >= DEPTH_CAP) doc_error();
            else begin
               tk_depth++;
               emit_event(EV_TAG_CLOSE);
               tk_depth--;
               emit_event(EV_END_ELEM);
               if (tk_depth == 0) doc_end(); else tk_mode = M_CONTENT;
            end
         end
         M_ENDNAME: begin
            if (c == CH_NUL) doc_error();
            else if (c == CH_GT) begin
               if (tk_depth == 0) doc_error();
               else begin
                  tk_depth--;
                  emit_event(EV_END_ELEM);
                  if (tk_depth == 0) doc_end(); else tk_mode = M_CONTENT;
               end
            end else emit_byte(c, CLS_ENDNAME);
         end
         M_BANG: begin
            if (c == CH_DASH) tk_mode = M_COMMENT_OPEN;
            else if (c == CH_LBRK) begin kw_pos = 1; tk_mode = M_KW_CDATA; end
            else if (c == CH_D) begin kw_pos = 1; tk_mode = M_KW_DOCTYPE; end
            else doc_error();
         end
         M_COMMENT_OPEN: begin
            if (c == CH_DASH) begin term_pos = 0; tk_mode = M_COMMENT; end
            else doc_error();
         end
         M_KW_CDATA, M_KW_DOCTYPE: begin
            string word;
            word = (tk_mode == M_KW_CDATA) ? "[CDATA[" : "DOCTYPE";
            kw = (kw_pos < 7) ? word[kw_pos] : 8'h00;
            if (kw_pos >= 7 || c != kw) doc_error();
            else begin
               kw_pos++;
               if (kw_pos == 7) begin
                  kw_pos = 0;
                  term_pos = 0;
                  if (tk_mode == M_KW_CDATA) tk_mode = M_CDATA;
                  else begin dt_nest = 1; tk_mode = M_DOCTYPE; end
               end
            end
         end
         M_COMMENT: begin
            seq = '{CH_DASH, CH_DASH, CH_GT};
            if (c == CH_NUL) doc_error();
            else begin
               match_term(seq, 3, c, CLS_COMMENT, hit);
               if (hit) begin emit_event(EV_CMNT_END); tk_mode = M_CONTENT; end
            end
         end
         M_CDATA: begin
            seq = '{CH_RBRK, CH_RBRK, CH_GT};
            if (c == CH_NUL) doc_error();
            else begin
               match_term(seq, 3, c, CLS_CHARS, hit);
               if (hit) begin emit_event(EV_CHARS_END); tk_mode = M_CONTENT; end
            end
         end
         M_PI: begin
            seq = '{CH_QM, CH_GT, CH_NUL};
            if (c == CH_NUL) doc_error();
            else begin
               match_term(seq, 2, c, CLS_NONE, hit);
               if (hit) tk_mode = M_CONTENT;
            end
         end
         M_DOCTYPE: begin
            if (c == CH_NUL) doc_error();
            else if (c == CH_LT) begin if (dt_nest < 255) dt_nest++; end
            else if (c == CH_GT) begin
               if (dt_nest > 0) dt_nest--;
               if (dt_nest == 0) tk_mode = M_CONTENT;
            end
         end
         default: ;
      endcase
   endtask

   // expected beats for one accepted input byte
   task automatic tokenize_byte(input logic [7:0] c, input logic last);
      step_beats = 0;
      if (tk_mode == M_DONE) return;
      if (tk_mode == M_IDLE) begin
         emit_event(EV_START_DOC);
         tk_mode = M_CONTENT;
      end
      parse_byte(c);
      if (last && tk_mode != M_DONE) parse_byte(CH_NUL);
      if (step_beats > 0) expected_beats[expected_beats.size() - 1].run_last = 1'b1;
   endtask

   // ---------------------------------------------------------------
   // Request side: one beat per call, driven on the falling edge
   // ---------------------------------------------------------------
   task automatic send_byte(input logic [7:0] c, input logic last = 1'b0);
      int gap;
      gap = quiet_req ? 0 : $urandom_range(0, 19);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid     <= 1'b1;
      req_in_byte   <= c;
      req_input_end <= last;
      do @(posedge clock); while (!req_ready);
      tokenize_byte(c, last);
      bytes_sent++;
      @(negedge clock);
   endtask

   task automatic send_text(input string s);
      for (int i = 0; i < s.len(); i++) send_byte(s[i]);
   endtask

   // ---------------------------------------------------------------
   // Response side: random stalls, plus a long hold-off on request
   // ---------------------------------------------------------------
   initial begin
      int n;
      rsp_ready = 1'b0;
      @(negedge reset);
      @(negedge clock);
      forever begin
         if (rsp_hold > 0) begin
            rsp_ready <= 1'b0;
            repeat (rsp_hold) @(negedge clock);
            rsp_hold = 0;
            rsp_ready <= 1'b1;
         end else begin
            n = quiet_rsp ? 0 : $urandom_range(0, 19);
            if (n > 0) begin
               rsp_ready <= 1'b0;
               repeat (n) @(negedge clock);
            end
            rsp_ready <= 1'b1;
         end
         do @(posedge clock); while (!rsp_valid);
         @(negedge clock);
      end
   end

   // compare every accepted result beat against the oldest prediction
   always @(posedge clock) begin
      rsp_type e;
      if (!reset && rsp_valid && rsp_ready) begin
         beats_seen++;
         if (expected_beats.size() == 0) begin
            $error("unexpected beat: event %0d byte %0h", rsp_event_res, rsp_out_byte);
            fail_count++;
         end else begin
            e = expected_beats.pop_front();
            if (e.event_res == EV_ERROR) errors_seen++;
            if (rsp_out_byte !== e.out_byte) begin
               $error("out_byte exp %0h got %0h", e.out_byte, rsp_out_byte);
               fail_count++;
            end
            if (rsp_byte_valid !== e.byte_valid) begin
               $error("byte_valid exp %0d got %0d", e.byte_valid, rsp_byte_valid);
               fail_count++;
            end
            if (rsp_byte_class !== e.byte_class) begin
               $error("byte_class exp %0d got %0d", e.byte_class, rsp_byte_class);
               fail_count++;
            end
            if (rsp_event_res !== e.event_res) begin
               $error("event_res exp %0d got %0d", e.event_res, rsp_event_res);
               fail_count++;
            end
            if (rsp_nesting_depth !== e.nesting_depth) begin
               $error("nesting_depth exp %0d got %0d", e.nesting_depth, rsp_nesting_depth);
               fail_count++;
            end
            if (rsp_run_last !== e.run_last) begin
               $error("run_last exp %0d got %0d", e.run_last, rsp_run_last);
               fail_count++;
            end
         end
      end
   end

   // ---------------------------------------------------------------
   // Random content pickers
   // ---------------------------------------------------------------
   function automatic logic [7:0] pick_name_byte(input bit attr);
      logic [7:0] b;
      do b = 8'($urandom_range(1, 255));
      while (is_blank(b) || b == CH_GT || b == CH_SLASH || (attr && b == CH_EQ));
      return b;
   endfunction

   function automatic logic [7:0] pick_text_byte();
      logic [7:0] b;
      do b = 8'($urandom_range(1, 255)); while (b == CH_LT);
      return b;
   endfunction

   function automatic logic [7:0] pick_value_byte(input logic [7:0] quote);
      logic [7:0] b;
      do b = 8'($urandom_range(1, 255)); while (b == quote || b == CH_GT);
      return b;
   endfunction

   function automatic logic [7:0] pick_blank();
      case ($urandom_range(0, 3))
         0: return CH_SP;
         1: return CH_TAB;
         2: return CH_LF;
         default: return CH_CR;
      endcase
   endfunction

   task automatic send_name(input bit attr);
      int n;
      n = $urandom_range(1, 4);
      repeat (n) send_byte(pick_name_byte(attr));
   endtask

   task automatic send_attr();
      logic [7:0] q;
      q = $urandom_range(0, 1) ? CH_SQ : CH_DQ;
      send_byte(CH_SP);
      send_name(1);
      if ($urandom_range(0, 3) == 0) send_byte(pick_blank());
      send_byte(CH_EQ);
      if ($urandom_range(0, 3) == 0) send_byte(pick_blank());
      send_byte(q);
      repeat ($urandom_range(0, 4)) send_byte(pick_value_byte(q));
      send_byte(q);
   endtask

   // start tag with random attributes; self-closing when asked
   task automatic send_start_tag(input bit empty_elem);
      send_byte(CH_LT);
      // first name byte must not open markup, so keep it a plain letter
      send_byte(8'(8'h61 + $urandom_range(0, 25)));
      repeat ($urandom_range(0, 2)) send_byte(pick_name_byte(0));
      repeat ($urandom_range(0, 2)) send_attr();
      if (empty_elem) send_byte(CH_SLASH);
      send_byte(CH_GT);
   endtask

   task automatic send_end_tag();
      send_byte(CH_LT);
      send_byte(CH_SLASH);
      send_name(0);
      send_byte(CH_GT);
   endtask

   task automatic send_text_run();
      int n;
      n = $urandom_range(1, 10);
      repeat (n) begin
         case ($urandom_range(0, 5))
            0: repeat ($urandom_range(1, 20)) send_byte(pick_blank());
            1: send_byte(pick_blank());
            default: send_byte(pick_text_byte());
         endcase
      end
   endtask

   task automatic send_comment();
      send_text("<!--");
      repeat ($urandom_range(0, 8))
         send_byte($urandom_range(0, 2) == 0 ? CH_DASH : 8'($urandom_range(1, 255)));
      send_text("-->");
   endtask

   task automatic send_cdata();
      send_text("<![CDATA[");
      repeat ($urandom_range(0, 8))
         send_byte($urandom_range(0, 2) == 0 ? CH_RBRK : 8'($urandom_range(1, 255)));
      send_text("]]>");
   endtask

   task automatic send_pi();
      send_text("<?");
      repeat ($urandom_range(0, 6))
         send_byte($urandom_range(0, 2) == 0 ? CH_QM : 8'($urandom_range(1, 255)));
      send_text("?>");
   endtask

   // ---------------------------------------------------------------
   // Tests, all within one document (end doc or error is final)
   // ---------------------------------------------------------------
   task automatic test_prolog();
      send_text(" <?x ??y?>");
      send_text("<!DOCTYPE r [<x>]>");
      send_text("<!---x--y-->");
   endtask

   task automatic test_root_attrs();
      send_text("<r a=\"1\" b = 'x\"y' c\t=\"\">");
   endtask

   task automatic test_text_and_tags();
      send_text(" hi \t x\n");
      send_text("                x");   // long blank run forces a release
      send_text("  \r<e/><f></f><g k='v'/>");
      send_byte(8'hFF);
      send_byte(8'h80);
      send_text("<h></>");              // empty end-tag name is allowed
   endtask

   task automatic test_comment_cdata();
      send_text("<!---a--->");
      send_text("<![CDATA[<]]x]]]>");
   endtask

   task automatic test_random_content(input int items);
      int stop_at;
      stop_at = bytes_sent + items;
      while (bytes_sent < stop_at) begin
         case ($urandom_range(0, 7))
            0, 1: if (tk_depth < 6) send_start_tag(0);
            2:    if (tk_depth > 1) send_end_tag();
            3:    send_start_tag(1);
            4:    send_text_run();
            5:    send_comment();
            6:    send_cdata();
            default: send_pi();
         endcase
      end
   endtask

   // block stalls its input while the receiver holds off
   task automatic test_backpressure();
      quiet_req = 1;
      rsp_hold  = 300;
      test_random_content(15);
      quiet_req = 0;
   endtask

   // ends the document one of several ways, then checks later bytes are ignored
   task automatic test_ending();
      bit ended_by_last;
      ended_by_last = 0;
      case ($urandom_range(0, 11))
         0: begin
            ending_name = "root close";
            while (tk_depth > 0) send_end_tag();
         end
         1: begin
            ending_name = "last-byte flag";
            send_byte(8'h7A, 1'b1);
            ended_by_last = 1;
         end
         2: begin ending_name = "zero in text"; send_text("ab"); send_byte(CH_NUL); end
         3: begin ending_name = "empty name"; send_text("<>"); end
         4: begin ending_name = "bad slash"; send_text("<a/x"); end
         5: begin ending_name = "empty attr name"; send_text("<a ="); end
         6: begin ending_name = "attr no equals"; send_text("<a b c"); end
         7: begin ending_name = "attr no quote"; send_text("<a b=x"); end
         8: begin ending_name = "bad bang"; send_text("<!x"); end
         9: begin ending_name = "zero in comment"; send_text("<!--a"); send_byte(CH_NUL); end
         10: begin ending_name = "gt in value"; send_text("<a b='>"); end
         default: begin
            ending_name = "zero in tag";
            send_text("<a");
            send_byte(CH_NUL);
         end
      endcase
      send_text("<z>");
      send_byte(8'h41, ended_by_last ? 1'b0 : 1'b1);
   endtask

   initial begin
      tk_mode = M_IDLE; kw_pos = 0; term_pos = 0; single_quote = 0;
      tk_depth = 0; dt_nest = 0; name_seen = 0; held_n = 0;
      fail_count = 0; beats_seen = 0; bytes_sent = 0; errors_seen = 0;
      quiet_req = 0; quiet_rsp = 0; rsp_hold = 0;
      reset = 1'b1;
      req_valid = 1'b0;
      req_in_byte = 8'h00;
      req_input_end = 1'b0;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_prolog();
      test_root_attrs();
      quiet_req = 1; quiet_rsp = 1;        // full-rate stretch
      test_text_and_tags();
      quiet_req = 0; quiet_rsp = 0;
      test_comment_cdata();
      test_random_content(RAND_ITEMS);
      test_backpressure();
      test_ending();
      req_valid <= 1'b0;

      wait (expected_beats.size() == 0);
      repeat (100) @(posedge clock);
      $display("Sent %0d bytes, checked %0d beats, %0d error events; ended by %s.",
               bytes_sent, beats_seen, errors_seen, ending_name);
      if (fail_count == 0 && expected_beats.size() == 0)
         $display("Regression PASS");
      else
         $display("Regression FAIL");
      $finish;
   end

   initial begin
      #50ms;
      $display("Regression FAIL");
      $finish;
   end

endmodule
